// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Small wrappers for concurrent assertions on clk with synchronous reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Plain invariant, disabled during reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`endif

// File: rtl/rgbc_pkg.sv
// ---------------------------------------------------------------------------
// RGBC to HSL package
// Shared widths, constants and the classified-sample struct.
// ---------------------------------------------------------------------------
package rgbc_pkg;

  localparam int CountW   = 16;
  localparam int PctW     = 7;
  localparam int HueW     = 9;
  localparam int QDepthDef = 32;

  localparam logic [PctW-1:0] PctFull = 7'd100;

  // hue branch select
  typedef enum logic [2:0] {
    BR_RED  = 3'b001,
    BR_GRN  = 3'b010,
    BR_BLU  = 3'b100
  } branch_t;

  // front end result, carried through the queue
  typedef struct packed {
    logic          clear_zero;
    logic          grey;
    branch_t       branch;
    logic          neg;        // numerator term below zero
    logic [PctW-1:0] num_mag;  // |hue numerator difference|, <= 100
    logic [PctW-1:0] dif;      // max - min
    logic [PctW:0]   sum;      // max + min
  } sample_t;

endpackage

// File: rtl/rgbc_divider.sv
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; numerator and divisor unsigned.
// ---------------------------------------------------------------------------
module rgbc_divider #(
  parameter int NumW = 16,
  parameter int DenW = 16,
  parameter int TagW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  input  logic [TagW-1:0] in_tag,
  output logic            out_valid,
  output logic [NumW-1:0] quo,
  output logic [TagW-1:0] out_tag
);

  logic [NumW-1:0] n_q   [NumW+1];
  logic [NumW-1:0] q_q   [NumW+1];
  logic [DenW:0]   r_q   [NumW+1];
  logic [DenW-1:0] d_q   [NumW+1];
  logic [TagW-1:0] t_q   [NumW+1];
  logic [NumW:0]   v_q;

  always_comb begin
    n_q[0] = num;
    q_q[0] = '0;
    r_q[0] = '0;
    d_q[0] = den;
    t_q[0] = in_tag;
    v_q[0] = in_valid;
  end

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [DenW+1:0] trial;
    logic [DenW+1:0] shifted;
    always_comb begin
      shifted = {r_q[s], n_q[s][NumW-1-s]};
      trial   = shifted - {2'b00, d_q[s]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s+1] <= 1'b0;
      end else if (en) begin
        v_q[s+1] <= v_q[s];
      end
      if (en) begin
        n_q[s+1] <= n_q[s];
        d_q[s+1] <= d_q[s];
        t_q[s+1] <= t_q[s];
        if (!trial[DenW+1]) begin
          r_q[s+1] <= trial[DenW:0];
          q_q[s+1] <= q_q[s] | (NumW'(1) << (NumW-1-s));
        end else begin
          r_q[s+1] <= shifted[DenW:0];
          q_q[s+1] <= q_q[s];
        end
      end
    end
  end

  assign out_valid = v_q[NumW];
  assign quo       = q_q[NumW];
  assign out_tag   = t_q[NumW];

endmodule

// File: rtl/rgbc_front.sv
// ---------------------------------------------------------------------------
// RGBC front end
// Normalizes counts to percent of clear and classifies the sample.
// ---------------------------------------------------------------------------
module rgbc_front
  import rgbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [CountW-1:0] red_count,
  input  logic [CountW-1:0] green_count,
  input  logic [CountW-1:0] blue_count,
  input  logic [CountW-1:0] clear_count,
  output logic              out_valid,
  output sample_t           out_sample
);

  localparam int NumW = CountW + PctW;

  logic [NumW-1:0] rq, gq, bq;
  logic            v_div;
  logic            cz_div, v2, v3;
  logic [PctW-1:0] r, g, b, r3, g3, b3;
  logic            cz2, cz3;

  // count*100 fits NumW bits; three dividers share clear as divisor
  rgbc_divider #(.NumW(NumW), .DenW(CountW), .TagW(1)) u_div_r (
    .clk, .rst, .en, .in_valid,
    .num(NumW'(red_count) * NumW'(PctFull)), .den(clear_count),
    .in_tag(clear_count == '0), .out_valid(v_div), .quo(rq), .out_tag(cz_div));
  rgbc_divider #(.NumW(NumW), .DenW(CountW), .TagW(1)) u_div_g (
    .clk, .rst, .en, .in_valid,
    .num(NumW'(green_count) * NumW'(PctFull)), .den(clear_count),
    .in_tag(1'b0), .out_valid(), .quo(gq), .out_tag());
  rgbc_divider #(.NumW(NumW), .DenW(CountW), .TagW(1)) u_div_b (
    .clk, .rst, .en, .in_valid,
    .num(NumW'(blue_count) * NumW'(PctFull)), .den(clear_count),
    .in_tag(1'b0), .out_valid(), .quo(bq), .out_tag());

  // clamp stage
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v_div;
    if (en) begin
      r   <= (rq > NumW'(PctFull)) ? PctFull : rq[PctW-1:0];
      g   <= (gq > NumW'(PctFull)) ? PctFull : gq[PctW-1:0];
      b   <= (bq > NumW'(PctFull)) ? PctFull : bq[PctW-1:0];
      cz2 <= cz_div;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      r3 <= r; g3 <= g; b3 <= b; cz3 <= cz2;
    end
  end

  logic [PctW-1:0] mx, mn;
  sample_t         s;
  always_comb begin
    mx = r3;
    if (g3 > mx) mx = g3;
    if (b3 > mx) mx = b3;
    mn = r3;
    if (g3 < mn) mn = g3;
    if (b3 < mn) mn = b3;
    s            = '0;
    s.clear_zero = cz3;
    s.dif        = mx - mn;
    s.sum        = {1'b0, mx} + {1'b0, mn};
    s.grey       = (mx == mn);
    if (mx == r3) begin
      s.branch  = BR_RED;
      s.neg     = g3 < b3;
      s.num_mag = s.neg ? b3 - g3 : g3 - b3;
    end else if (mx == g3) begin
      s.branch  = BR_GRN;
      s.neg     = b3 < r3;
      s.num_mag = s.neg ? r3 - b3 : b3 - r3;
    end else begin
      s.branch  = BR_BLU;
      s.neg     = r3 < g3;
      s.num_mag = s.neg ? g3 - r3 : r3 - g3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v3;
    if (en) out_sample <= s;
  end

endmodule

// File: rtl/rgbc_queue.sv
// ---------------------------------------------------------------------------
// RGBC sample queue
// Small FIFO between front and back ends; holds in-flight pipeline beats.
// ---------------------------------------------------------------------------
module rgbc_queue
  import rgbc_pkg::*;
#(
  parameter int Depth = QDepthDef
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  sample_t wr_data,
  input  logic    rd_en,
  output logic    rd_valid,
  output sample_t rd_data,
  output logic [$clog2(Depth+1)-1:0] count
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  sample_t        mem [Depth];
  logic [AW-1:0]  wp, rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      if (wr_en) wp <= (wp == AW'(Depth-1)) ? '0 : wp + 1'b1;
      if (rd_en) rp <= (rp == AW'(Depth-1)) ? '0 : rp + 1'b1;
      count <= count + (wr_en ? 1'b1 : 1'b0) - (rd_en ? 1'b1 : 1'b0);
    end
    if (wr_en) mem[wp] <= wr_data;
  end

  assign rd_valid = (count != '0);
  assign rd_data  = mem[rp];

endmodule

// File: rtl/rgbc_back.sv
// ---------------------------------------------------------------------------
// RGBC back end
// Hue and saturation divisions, final assembly, output register.
// ---------------------------------------------------------------------------
module rgbc_back
  import rgbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  sample_t               in_sample,
  output logic                  out_valid,
  output logic [HueW-1:0]       hue,
  output logic [PctW-1:0]       saturation,
  output logic [PctW-1:0]       lightness,
  output logic                  clear_zero
);

  localparam int HNumW = 13;  // 60*100
  localparam int SNumW = 14;  // 100*100
  localparam int TagW  = 1 + 1 + 3 + 1 + PctW;

  logic [PctW:0]   sden;
  logic [PctW-1:0] lit;
  always_comb begin
    lit  = in_sample.sum[PctW:1];
    sden = (lit <= PctW'(50)) ? in_sample.sum : 8'd200 - in_sample.sum;
  end

  logic [HNumW-1:0] hq;
  logic [SNumW-1:0] sq;
  logic             hv;
  logic [TagW-1:0]  tag;

  // grey beats divide by one to keep dividers defined
  rgbc_divider #(.NumW(HNumW), .DenW(PctW), .TagW(TagW)) u_div_h (
    .clk, .rst, .en, .in_valid,
    .num(HNumW'(in_sample.num_mag) * HNumW'(60)),
    .den(in_sample.grey ? PctW'(1) : in_sample.dif),
    .in_tag({in_sample.clear_zero, in_sample.grey, in_sample.branch,
             in_sample.neg, lit}),
    .out_valid(hv), .quo(hq), .out_tag(tag));
  // pad so both finish together
  logic [SNumW-1:0] sq_raw;
  rgbc_divider #(.NumW(SNumW), .DenW(PctW+1), .TagW(1)) u_div_s (
    .clk, .rst, .en, .in_valid,
    .num(SNumW'(in_sample.dif) * SNumW'(100)),
    .den(in_sample.grey ? (PctW+1)'(1) : sden),
    .in_tag(1'b0), .out_valid(), .quo(sq_raw), .out_tag());
  logic [HNumW-1:0] hq_d;
  logic [TagW-1:0]  tag_d;
  logic             hv_d;
  always_ff @(posedge clk) begin
    if (rst) hv_d <= 1'b0;
    else if (en) hv_d <= hv;
    if (en) begin
      hq_d <= hq; tag_d <= tag;
    end
  end
  assign sq = sq_raw;

  logic          t_cz, t_grey, t_neg;
  logic [2:0]    t_br_raw;
  branch_t       t_br;
  logic [PctW-1:0] t_lit;
  logic [HueW:0]   h;
  always_comb begin
    {t_cz, t_grey, t_br_raw, t_neg, t_lit} = tag_d;
    t_br = branch_t'(t_br_raw);
    unique case (t_br)
      BR_RED:  h = t_neg ? 10'd360 - 10'(hq_d) : 10'(hq_d);
      BR_GRN:  h = t_neg ? 10'd120 - 10'(hq_d) : 10'd120 + 10'(hq_d);
      BR_BLU:  h = t_neg ? 10'd240 - 10'(hq_d) : 10'd240 + 10'(hq_d);
      default: h = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= hv_d;
    if (en) begin
      clear_zero <= t_cz;
      if (t_cz) begin
        hue <= '0; saturation <= '0; lightness <= '0;
      end else if (t_grey) begin
        hue <= '0; saturation <= '0; lightness <= t_lit;
      end else begin
        hue <= h[HueW-1:0]; saturation <= sq[PctW-1:0]; lightness <= t_lit;
      end
    end
  end

endmodule

// File: rtl/rgbc_to_hsl_converter.sv
// ---------------------------------------------------------------------------
// RGBC to HSL converter
// Color sensor sample (R,G,B,clear) to integer hue/saturation/lightness.
// ---------------------------------------------------------------------------
// Usage:
//  Input beats on s_axis (tdata = red, green, blue, clear, 16 bits each,
//  red lowest). Output beats on m_axis (tdata = hue, saturation, lightness,
//  low bits up, zero padded to 24 bits; tuser = clear_zero).
//  One beat is accepted per cycle while s_axis_tready is high; the datapath
//  is a chain of pipeline stages: 23 divider stages for the percent divides,
//  3 for clamp and classify, 1 for the queue write, 14 for saturation, then
//  the output register for assembly. Throughput is one sample per cycle when nothing stalls.
//  The front pipeline always runs; a queue of QDepth entries catches beats
//  still in flight when the receiver stalls, and s_axis_tready drops once
//  queued plus in-flight beats could overflow it. The back end drains the
//  queue and freezes while an output beat waits.
//  Reset clears all valid flags and the queue pointers.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module rgbc_to_hsl_converter
  import rgbc_pkg::*;
#(
  parameter int QDepth = QDepthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // red, green, blue, clear
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // hue, saturation, lightness, zero pad
  output logic        m_axis_tuser    // clear_zero
);

  // Front pipeline always runs; queue bounds occupancy by credit.
  localparam int FrontLat = CountW + PctW + 3;
  localparam int CW = $clog2(QDepth+1);

  logic              f_valid;
  sample_t           f_sample;
  logic [CW-1:0]     q_count;
  logic [$clog2(FrontLat+2)-1:0] inflight;
  logic              q_valid, q_rd;
  sample_t           q_data;
  logic              acc;

  assign acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (32'(q_count) + 32'(inflight)) < 32'(QDepth - 1);

  always_ff @(posedge clk) begin
    if (rst) inflight <= '0;
    else inflight <= inflight + (acc ? 1'b1 : 1'b0) - (f_valid ? 1'b1 : 1'b0);
  end

  rgbc_front u_front (
    .clk, .rst, .en(1'b1), .in_valid(acc),
    .red_count(s_axis_tdata[15:0]), .green_count(s_axis_tdata[31:16]),
    .blue_count(s_axis_tdata[47:32]), .clear_count(s_axis_tdata[63:48]),
    .out_valid(f_valid), .out_sample(f_sample));

  rgbc_queue #(.Depth(QDepth)) u_q (
    .clk, .rst, .wr_en(f_valid), .wr_data(f_sample),
    .rd_en(q_rd), .rd_valid(q_valid), .rd_data(q_data), .count(q_count));

  // back pipeline moves when output is free
  logic        b_en, b_valid;
  logic [HueW-1:0] hue;
  logic [PctW-1:0] sat, lit;
  logic        cz;
  assign b_en = !m_axis_tvalid || m_axis_tready;
  assign q_rd = q_valid && b_en;

  rgbc_back u_back (
    .clk, .rst, .en(b_en), .in_valid(q_rd), .in_sample(q_data),
    .out_valid(b_valid), .hue, .saturation(sat), .lightness(lit),
    .clear_zero(cz));

  assign m_axis_tvalid = b_valid;
  assign m_axis_tdata  = {1'b0, lit, sat, hue};
  assign m_axis_tuser  = cz;

  `ASSERT_IMPL(a_q_no_ovf, clk, rst, f_valid, q_count < CW'(QDepth), "queue overflow")
  `ASSERT_IMPL(a_cz_zero, clk, rst, m_axis_tvalid && m_axis_tuser,
               m_axis_tdata == '0, "clear_zero with nonzero fields")
  `ASSERT_ALWAYS(a_hue_rng, clk, rst, !m_axis_tvalid || m_axis_tdata[8:0] <= 9'd360,
                 "hue out of range")

endmodule

// File: tb/sv/rgbc_to_hsl_converter_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// RGBC to HSL checker
// Watches both stream channels, predicts each output beat from the input
// beat it belongs to, and compares field by field in order.
// ---------------------------------------------------------------------------
module rgbc_to_hsl_converter_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // red, green, blue, clear
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // hue, saturation, lightness, zero pad
  input  logic        m_axis_tuser,   // clear_zero
  output int          err_count,
  output int          pending
);

  typedef struct packed {
    logic       clear_zero;
    logic [6:0] lightness;
    logic [6:0] saturation;
    logic [8:0] hue;
  } hsl_t;

  hsl_t hsl_q[$];

  function automatic int pct_of(logic [15:0] cnt, logic [15:0] clr);
    int q;
    q = (int'(cnt) * 100) / int'(clr);
    return (q > 100) ? 100 : q;
  endfunction

  function automatic hsl_t to_hsl(logic [63:0] d);
    int r, g, b, mx, mn, dif, sum, lit, h, s;
    hsl_t o;
    o = '0;
    if (d[63:48] == 16'd0) begin
      o.clear_zero = 1'b1;
      return o;
    end
    r = pct_of(d[15:0], d[63:48]);
    g = pct_of(d[31:16], d[63:48]);
    b = pct_of(d[47:32], d[63:48]);
    mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
    mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
    dif = mx - mn;
    sum = mx + mn;
    lit = sum / 2;
    h = 0;
    s = 0;
    if (dif != 0) begin
      // SV int division truncates toward zero, like the hardware intent
      if (mx == r) begin
        h = (60 * (g - b)) / dif;
        if (g < b) h += 360;
      end else if (mx == g) begin
        h = (60 * (b - r)) / dif + 120;
      end else begin
        h = (60 * (r - g)) / dif + 240;
      end
      s = (lit <= 50) ? (dif * 100) / sum : (dif * 100) / (200 - sum);
    end
    o.hue = h[8:0];
    o.saturation = s[6:0];
    o.lightness = lit[6:0];
    return o;
  endfunction

  always @(posedge clk) begin
    hsl_t want, got;
    if (rst) begin
      err_count <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        hsl_q.push_back(to_hsl(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[22:0]};
        if (hsl_q.size() == 0) begin
          $error("unexpected output beat %h", m_axis_tdata);
          err_count <= err_count + 1;
        end else begin
          want = hsl_q.pop_front();
          if (got.hue !== want.hue)
            $error("hue: expected %0d, got %0d", want.hue, got.hue);
          if (got.saturation !== want.saturation)
            $error("saturation: expected %0d, got %0d", want.saturation, got.saturation);
          if (got.lightness !== want.lightness)
            $error("lightness: expected %0d, got %0d", want.lightness, got.lightness);
          if (got.clear_zero !== want.clear_zero)
            $error("clear_zero: expected %0d, got %0d", want.clear_zero, got.clear_zero);
          if (got !== want)
            err_count <= err_count + 1;
        end
      end
    end
    pending <= hsl_q.size();
  end

endmodule

// File: tb/sv/rgbc_to_hsl_converter_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// RGBC to HSL converter testbench
// Directed corner samples, then random samples with random gaps on input and
// random stalls on output, including one long output hold-off.
// ---------------------------------------------------------------------------
module rgbc_to_hsl_converter_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // red, green, blue, clear
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // hue, saturation, lightness, zero pad
  logic        m_axis_tuser;        // clear_zero
  int          err_count;
  int          pending;
  bit          send_done = 1'b0;
  bit          hold_off = 1'b0;

  always #1 clk = ~clk;

  rgbc_to_hsl_converter u_top (.*);

  rgbc_to_hsl_converter_checker u_chk (.*);

  // valid stays up between back-to-back beats; dropped only for a gap
  task automatic send_sample(logic [15:0] r, g, b, c);
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
    if (n != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c, b, g, r};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly small counts so ratios spread over 0..100; some full-range noise
  function automatic logic [15:0] rnd_cnt(logic [15:0] c);
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1:       return c;
      2:       return 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(0, 32'(c) + 32'(c) / 4));
    endcase
  endfunction

  initial begin
    logic [15:0] c;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // extremes, clamp, zero clear, grey, and each hue branch
    send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'h1234, 16'h0001, 16'h0000);
    send_sample(16'hFFFF, 16'h0000, 16'h0000, 16'h0001);
    send_sample(16'd50, 16'd50, 16'd50, 16'd100);
    send_sample(16'd0, 16'd0, 16'd0, 16'd100);
    send_sample(16'd100, 16'd40, 16'd10, 16'd100);
    send_sample(16'd100, 16'd10, 16'd40, 16'd100);
    send_sample(16'd100, 16'd0, 16'd1, 16'd100);
    send_sample(16'd30, 16'd90, 16'd10, 16'd100);
    send_sample(16'd10, 16'd90, 16'd30, 16'd100);
    send_sample(16'd30, 16'd10, 16'd90, 16'd100);
    send_sample(16'd10, 16'd30, 16'd90, 16'd100);
    send_sample(16'd90, 16'd90, 16'd20, 16'd100);
    send_sample(16'd20, 16'd90, 16'd90, 16'd100);
    send_sample(16'd90, 16'd80, 16'd70, 16'd100);
    send_sample(16'd5, 16'd0, 16'd0, 16'd100);
    send_sample(16'd0, 16'd0, 16'd0, 16'hFFFF);
    send_sample(16'hAAAA, 16'h5555, 16'hFFFF, 16'hFFFF);
    send_sample(16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF);
    for (int i = 0; i < 1330; i++) begin
      if (i == 400) hold_off <= 1'b1;
      case ($urandom_range(0, 7))
        0:       c = 16'($urandom);
        1:       c = 16'd0;
        default: c = 16'($urandom_range(1, 400));
      endcase
      send_sample(rnd_cnt(c), rnd_cnt(c), rnd_cnt(c), c);
    end
    s_axis_tvalid <= 1'b0;
    send_done <= 1'b1;
  end

  // output side: random stalls, one long hold-off while input keeps coming
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        for (int k = 0; k < 400; k++) @(negedge clk);
        hold_off = 1'b0;
      end
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
      if (n != 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(negedge clk);
    end
  end

  initial begin
    wait (send_done);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/rgbc_pkg.sv
rtl/rgbc_divider.sv
rtl/rgbc_front.sv
rtl/rgbc_queue.sv
rtl/rgbc_back.sv
rtl/rgbc_to_hsl_converter.sv
tb/sv/rgbc_to_hsl_converter_checker.sv
tb/sv/rgbc_to_hsl_converter_tb.sv
